// ===== rtl/core/sbt_pkg.sv =====
// Token kinds, scanner modes and keyword lookup for the source byte tokenizer.
package sbt_pkg;

  localparam int unsigned OffsetWidthDef = 24;
  localparam int unsigned LineWidthDef   = 16;
  localparam int unsigned LengthWidthDef = 16;
  localparam int unsigned KindWidth      = 6;
  localparam int unsigned PrefixBytes    = 6;

  localparam logic [KindWidth-1:0] KVar        = 6'd0;
  localparam logic [KindWidth-1:0] KSemi       = 6'd1;
  localparam logic [KindWidth-1:0] KLbrace     = 6'd2;
  localparam logic [KindWidth-1:0] KRbrace     = 6'd3;
  localparam logic [KindWidth-1:0] KPlus       = 6'd4;
  localparam logic [KindWidth-1:0] KMinus      = 6'd5;
  localparam logic [KindWidth-1:0] KStar       = 6'd6;
  localparam logic [KindWidth-1:0] KSlash      = 6'd7;
  localparam logic [KindWidth-1:0] KEq         = 6'd8;
  localparam logic [KindWidth-1:0] KEqEq       = 6'd9;
  localparam logic [KindWidth-1:0] KBang       = 6'd10;
  localparam logic [KindWidth-1:0] KBangEq     = 6'd11;
  localparam logic [KindWidth-1:0] KIdent      = 6'd12;
  localparam logic [KindWidth-1:0] KString     = 6'd13;
  localparam logic [KindWidth-1:0] KNumber     = 6'd14;
  localparam logic [KindWidth-1:0] KAnd        = 6'd15;
  localparam logic [KindWidth-1:0] KClass      = 6'd16;
  localparam logic [KindWidth-1:0] KElse       = 6'd17;
  localparam logic [KindWidth-1:0] KFalse      = 6'd18;
  localparam logic [KindWidth-1:0] KFor        = 6'd19;
  localparam logic [KindWidth-1:0] KIf         = 6'd20;
  localparam logic [KindWidth-1:0] KNil        = 6'd21;
  localparam logic [KindWidth-1:0] KOr         = 6'd22;
  localparam logic [KindWidth-1:0] KPower      = 6'd23;
  localparam logic [KindWidth-1:0] KEof        = 6'd24;
  localparam logic [KindWidth-1:0] KFunc       = 6'd29;
  localparam logic [KindWidth-1:0] KReturn     = 6'd30;
  localparam logic [KindWidth-1:0] KWhile      = 6'd31;
  localparam logic [KindWidth-1:0] KTrue       = 6'd32;
  localparam logic [KindWidth-1:0] KLess       = 6'd33;
  localparam logic [KindWidth-1:0] KLessEq     = 6'd34;
  localparam logic [KindWidth-1:0] KGreater    = 6'd35;
  localparam logic [KindWidth-1:0] KGreaterEq  = 6'd36;
  localparam logic [KindWidth-1:0] KComma      = 6'd37;
  localparam logic [KindWidth-1:0] KDot        = 6'd38;
  localparam logic [KindWidth-1:0] KLparen     = 6'd40;
  localparam logic [KindWidth-1:0] KRparen     = 6'd41;
  localparam logic [KindWidth-1:0] KUnterm     = 6'd42;
  localparam logic [KindWidth-1:0] KUnexpected = 6'd43;

  localparam logic [2:0] MIdle     = 3'd0;
  localparam logic [2:0] MIdent    = 3'd1;
  localparam logic [2:0] MNumber   = 3'd2;
  localparam logic [2:0] MNumDot   = 3'd3;
  localparam logic [2:0] MFraction = 3'd4;
  localparam logic [2:0] MString   = 3'd5;
  localparam logic [2:0] MComment  = 3'd6;
  localparam logic [2:0] MOperator = 3'd7;

  // Prefix holds the first byte in its low byte, so literals are concatenated
  // last character first.
  function automatic logic [KindWidth-1:0] kw_kind(input logic [47:0] pf,
                                                   input logic [2:0] n);
    logic [KindWidth-1:0] k;
    k = KIdent;
    case (n)
      3'd2: begin
        if (pf[15:0] == {"f", "i"}) k = KIf;
        else if (pf[15:0] == {"r", "o"}) k = KOr;
      end
      3'd3: begin
        if (pf[23:0] == {"d", "n", "a"}) k = KAnd;
        else if (pf[23:0] == {"r", "o", "f"}) k = KFor;
        else if (pf[23:0] == {"l", "i", "n"}) k = KNil;
      end
      3'd4: begin
        if (pf[31:0] == {"e", "s", "l", "e"}) k = KElse;
        else if (pf[31:0] == {"c", "n", "u", "f"}) k = KFunc;
        else if (pf[31:0] == {"e", "u", "r", "t"}) k = KTrue;
      end
      3'd5: begin
        if (pf[39:0] == {"s", "s", "a", "l", "c"}) k = KClass;
        else if (pf[39:0] == {"t", "s", "n", "o", "c"}) k = KVar;
        else if (pf[39:0] == {"e", "s", "l", "a", "f"}) k = KFalse;
        else if (pf[39:0] == {"e", "l", "i", "h", "w"}) k = KWhile;
      end
      3'd6: begin
        if (pf == {"n", "r", "u", "t", "e", "r"}) k = KReturn;
      end
      default: k = KIdent;
    endcase
    return k;
  endfunction

  function automatic logic [KindWidth-1:0] op_single(input logic [7:0] c);
    case (c)
      "*":     return KStar;
      "!":     return KBang;
      "=":     return KEq;
      "<":     return KLess;
      default: return KGreater;
    endcase
  endfunction

  function automatic logic [KindWidth-1:0] op_double(input logic [7:0] c);
    case (c)
      "*":     return KPower;
      "!":     return KBangEq;
      "=":     return KEqEq;
      "<":     return KLessEq;
      default: return KGreaterEq;
    endcase
  endfunction

endpackage

// ===== rtl/core/source_byte_tokenizer_top.sv =====
// Streaming source tokenizer: bytes in, tokens out through a small result queue.
// A token completed by an accepted byte is queued, and presented once earlier tokens drain.
// Throughput: one byte per cycle while the four-entry result queue holds at most one token;
// a byte can produce up to three tokens, which then drain at one per cycle while out_ready_i is high.
// Reset (asynchronous, active low) empties the queue and returns the scanner to idle,
// offset zero and line one.
module source_byte_tokenizer_top
  import sbt_pkg::*;
#(
  parameter int unsigned OffsetWidth = OffsetWidthDef,
  parameter int unsigned LineWidth   = LineWidthDef,
  parameter int unsigned LengthWidth = LengthWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             source_byte_i,
  input  logic                   end_of_source_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [KindWidth-1:0]   token_kind_o,
  output logic [OffsetWidth-1:0] token_start_o,
  output logic [LengthWidth-1:0] token_length_o,
  output logic [LineWidth-1:0]   token_line_o,
  output logic                   last_of_run_o
);

  typedef struct packed {
    logic [KindWidth-1:0]   kind;
    logic [OffsetWidth-1:0] start;
    logic [LengthWidth-1:0] len;
    logic [LineWidth-1:0]   line;
    logic                   last;
  } token_t;

  localparam int unsigned Depth = 4;

  // Scanner state
  logic [2:0]             mode_q, mode_d;
  logic [7:0]             pend_q, pend_d;
  logic [OffsetWidth-1:0] start_q, start_d;
  logic [OffsetWidth-1:0] pos_q, pos_d;
  logic [LineWidth-1:0]   line_q, line_d;
  logic [LengthWidth-1:0] len_q, len_d;
  logic [47:0]            pfx_q, pfx_d;

  // Result queue
  token_t     fifo_q [Depth];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;

  logic in_acc, out_acc, done;
  logic [7:0] c;
  logic is_letter, is_numeral;
  logic [LengthWidth:0]   len_p1, len_p2;
  logic [LengthWidth-1:0] len_s1, len_s2;
  logic [KindWidth-1:0]   idk;
  logic [OffsetWidth-1:0] prev;
  logic   a_v, b_v, c_v, absorbed;
  token_t tok_a, tok_b, tok_c;
  token_t slot0, slot1, slot2;
  logic [1:0] n_push;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;
  assign c       = source_byte_i;
  assign done    = end_of_source_i | (c == 8'd0);

  assign is_letter  = (c inside {["a":"z"], ["A":"Z"], "_"});
  assign is_numeral = (c inside {["0":"9"]});

  // Saturating length increments
  assign len_p1 = {1'b0, len_q} + (LengthWidth+1)'(1);
  assign len_p2 = {1'b0, len_q} + (LengthWidth+1)'(2);
  assign len_s1 = len_p1[LengthWidth] ? '1 : len_p1[LengthWidth-1:0];
  assign len_s2 = len_p2[LengthWidth] ? '1 : len_p2[LengthWidth-1:0];

  // Keywords are at most six bytes; anything longer is a plain identifier
  assign idk  = (len_q > LengthWidth'(PrefixBytes)) ? KIdent : kw_kind(pfx_q, len_q[2:0]);
  assign prev = pos_q - OffsetWidth'(1);

  // Next state and up to three tokens: a flushed lexeme (a), a trailing dot (b)
  // and either eof or a token from the byte itself (c).
  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    start_d = start_q;
    pos_d   = pos_q;
    line_d  = line_q;
    len_d   = len_q;
    pfx_d   = pfx_q;
    a_v = 1'b0;
    b_v = 1'b0;
    c_v = 1'b0;
    absorbed = 1'b1;
    tok_a = '{kind: KIdent, start: start_q, len: len_q, line: line_q, last: 1'b0};
    tok_b = '{kind: KDot, start: prev, len: LengthWidth'(1), line: line_q, last: 1'b0};
    tok_c = '{kind: KEof, start: pos_q, len: '0, line: line_q, last: 1'b0};

    if (done) begin
      // Flush whatever is pending, then eof, then back to reset state
      case (mode_q)
        MIdent: begin
          a_v = 1'b1;
          tok_a.kind = idk;
        end
        MNumber, MFraction: begin
          a_v = 1'b1;
          tok_a.kind = KNumber;
        end
        MNumDot: begin
          a_v = 1'b1;
          b_v = 1'b1;
          tok_a.kind = KNumber;
        end
        MString: begin
          a_v = 1'b1;
          tok_a.kind = KUnterm;
        end
        MOperator: begin
          a_v = 1'b1;
          tok_a.kind = op_single(pend_q);
          tok_a.len  = LengthWidth'(1);
        end
        default: ;
      endcase
      c_v     = 1'b1;
      mode_d  = MIdle;
      pend_d  = '0;
      start_d = '0;
      pos_d   = '0;
      line_d  = LineWidth'(1);
      len_d   = '0;
      pfx_d   = '0;
    end else begin
      case (mode_q)
        MIdent: begin
          if (is_letter || is_numeral) begin
            if (len_q < LengthWidth'(PrefixBytes)) pfx_d[8*len_q[2:0] +: 8] = c;
            len_d = len_s1;
          end else begin
            a_v = 1'b1;
            tok_a.kind = idk;
            absorbed = 1'b0;
          end
        end
        MNumber: begin
          if (is_numeral) len_d = len_s1;
          else if (c == ".") mode_d = MNumDot;
          else begin
            a_v = 1'b1;
            tok_a.kind = KNumber;
            absorbed = 1'b0;
          end
        end
        MNumDot: begin
          if (is_numeral) begin
            len_d  = len_s2;
            mode_d = MFraction;
          end else begin
            a_v = 1'b1;
            b_v = 1'b1;
            tok_a.kind = KNumber;
            absorbed = 1'b0;
          end
        end
        MFraction: begin
          if (is_numeral) len_d = len_s1;
          else begin
            a_v = 1'b1;
            tok_a.kind = KNumber;
            absorbed = 1'b0;
          end
        end
        MString: begin
          len_d = len_s1;
          if (c == "\"") begin
            a_v = 1'b1;
            tok_a.kind = KString;
            tok_a.len  = len_s1;
            mode_d = MIdle;
          end else if (c == "\n") begin
            line_d = line_q + LineWidth'(1);
          end
        end
        MComment: begin
          if (c == "\n") absorbed = 1'b0;
        end
        MOperator: begin
          if ((pend_q == "*" && c == "*") || (pend_q != "*" && c == "=")) begin
            a_v = 1'b1;
            tok_a.kind = op_double(pend_q);
            tok_a.len  = LengthWidth'(2);
            mode_d = MIdle;
          end else begin
            a_v = 1'b1;
            tok_a.kind = op_single(pend_q);
            tok_a.len  = LengthWidth'(1);
            absorbed = 1'b0;
          end
        end
        default: absorbed = 1'b0;
      endcase

      // Rescan the byte from idle
      if (!absorbed) begin
        mode_d = MIdle;
        pend_d = '0;
        tok_c.start = pos_q;
        tok_c.len   = LengthWidth'(1);
        if (c inside {" ", 8'h0d, 8'h09}) begin
          // drop blanks
        end else if (c == "\n") begin
          line_d = line_q + LineWidth'(1);
        end else if (c == "#") begin
          mode_d = MComment;
        end else if (is_letter) begin
          mode_d  = MIdent;
          start_d = pos_q;
          len_d   = LengthWidth'(1);
          pfx_d   = {40'd0, c};
        end else if (is_numeral) begin
          mode_d  = MNumber;
          start_d = pos_q;
          len_d   = LengthWidth'(1);
        end else if (c == "\"") begin
          mode_d  = MString;
          start_d = pos_q;
          len_d   = LengthWidth'(1);
        end else if (c inside {"*", "!", "=", "<", ">"}) begin
          mode_d  = MOperator;
          pend_d  = c;
          start_d = pos_q;
          len_d   = LengthWidth'(1);
        end else begin
          c_v = 1'b1;
          case (c)
            "(":     tok_c.kind = KLparen;
            ")":     tok_c.kind = KRparen;
            "{":     tok_c.kind = KLbrace;
            "}":     tok_c.kind = KRbrace;
            ";":     tok_c.kind = KSemi;
            ",":     tok_c.kind = KComma;
            ".":     tok_c.kind = KDot;
            "-":     tok_c.kind = KMinus;
            "+":     tok_c.kind = KPlus;
            "/":     tok_c.kind = KSlash;
            default: tok_c.kind = KUnexpected;
          endcase
        end
      end
      pos_d = pos_q + OffsetWidth'(1);
    end

    // Mark the final token of this item
    tok_c.last = c_v;
    tok_b.last = b_v & ~c_v;
    tok_a.last = a_v & ~b_v & ~c_v;
  end

  // Pack valid tokens in order; the dot only ever follows a flushed number
  always_comb begin
    slot0 = tok_c;
    slot1 = tok_c;
    slot2 = tok_c;
    if (a_v && b_v) begin
      slot0 = tok_a;
      slot1 = tok_b;
    end else if (a_v) begin
      slot0 = tok_a;
    end
    n_push = 2'(a_v) + 2'(b_v) + 2'(c_v);
  end

  // Room for three tokens before taking a byte
  assign in_ready_o  = (cnt_q <= 3'd1);
  assign out_valid_o = (cnt_q != 3'd0);

  assign token_kind_o   = fifo_q[rptr_q].kind;
  assign token_start_o  = fifo_q[rptr_q].start;
  assign token_length_o = fifo_q[rptr_q].len;
  assign token_line_o   = fifo_q[rptr_q].line;
  assign last_of_run_o  = fifo_q[rptr_q].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MIdle;
      pend_q  <= '0;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= LineWidth'(1);
      len_q   <= '0;
      pfx_q   <= '0;
      wptr_q  <= '0;
      rptr_q  <= '0;
      cnt_q   <= '0;
    end else begin
      if (in_acc) begin
        mode_q  <= mode_d;
        pend_q  <= pend_d;
        start_q <= start_d;
        pos_q   <= pos_d;
        line_q  <= line_d;
        len_q   <= len_d;
        pfx_q   <= pfx_d;
        wptr_q  <= wptr_q + n_push;
      end
      if (out_acc) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + (in_acc ? {1'b0, n_push} : 3'd0) - {2'b0, out_acc};
    end
  end

  // Queue storage: payload only, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (n_push > 2'd0) fifo_q[wptr_q] <= slot0;
      if (n_push > 2'd1) fifo_q[wptr_q + 2'd1] <= slot1;
      if (n_push > 2'd2) fifo_q[wptr_q + 2'd2] <= slot2;
    end
  end

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'(Depth))
    else $error("result queue overflow");

  // End of source returns the scanner to its reset position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && done |=> (mode_q == MIdle) && (pos_q == '0))
    else $error("scanner not reset after end of source");

  // Every ordinary byte advances the offset by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !done |=> pos_q == $past(pos_q) + OffsetWidth'(1))
    else $error("byte offset did not advance");

  // An item with results always leaves one marked as last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (n_push != 2'd0) |-> (slot0.last || slot1.last || slot2.last))
    else $error("result run without last marker");

endmodule

// ===== verif/tb_source_byte_tokenizer_top.sv =====
// Self-checking testbench for the source byte tokenizer: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module tb_source_byte_tokenizer_top;
  import sbt_pkg::*;

  typedef struct packed {
    logic [KindWidth-1:0]      kind;
    logic [OffsetWidthDef-1:0] start;
    logic [LengthWidthDef-1:0] len;
    logic [LineWidthDef-1:0]   line;
    logic                      last;
  } token_t;

  // Scoreboard: mirrors the scanner state and queues the tokens each transfer should produce.
  class token_scoreboard;
    token_t     tokens_due[$];
    token_t     step_tokens[$];
    int         mismatches;
    int         tokens_seen;
    string      kw_text[13];
    logic [5:0] kw_kind[13];
    logic [2:0]  mode;
    logic [7:0]  held_op;
    logic [23:0] lex_start;
    logic [23:0] pos;
    logic [15:0] line;
    logic [15:0] lex_len;
    logic [47:0] prefix;

    function new();
      kw_text = '{"and", "class", "const", "else", "false", "for", "func", "if", "nil",
                  "or", "return", "true", "while"};
      kw_kind = '{KAnd, KClass, KVar, KElse, KFalse, KFor, KFunc, KIf, KNil, KOr,
                  KReturn, KTrue, KWhile};
      mismatches  = 0;
      tokens_seen = 0;
      clear();
    endfunction

    function void clear();
      mode = MIdle; held_op = 8'd0; lex_start = '0; pos = '0;
      line = 16'd1; lex_len = '0; prefix = '0;
    endfunction

    function void push(logic [5:0] k, logic [23:0] s, logic [15:0] l);
      token_t t;
      if (step_tokens.size() >= 3) return;
      t.kind = k; t.start = s; t.len = l; t.line = line; t.last = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function logic [15:0] grow(logic [15:0] a, int b);
      return (int'(a) + b > 65535) ? 16'hffff : a + 16'(b);
    endfunction

    function bit letter_byte(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit numeral_byte(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    // Match the whole lexeme against the keyword list.
    function logic [5:0] word_kind();
      bit hit;
      if (lex_len > 6) return KIdent;
      for (int i = 0; i < 13; i++) begin
        if (kw_text[i].len() == lex_len) begin
          hit = 1;
          for (int j = 0; j < kw_text[i].len(); j++)
            if (prefix[8*j +: 8] != kw_text[i][j]) hit = 0;
          if (hit) return kw_kind[i];
        end
      end
      return KIdent;
    endfunction

    function logic [5:0] one_char_op(logic [7:0] c);
      case (c)
        "*":     return KStar;
        "!":     return KBang;
        "=":     return KEq;
        "<":     return KLess;
        default: return KGreater;
      endcase
    endfunction

    function logic [5:0] two_char_op(logic [7:0] c);
      case (c)
        "*":     return KPower;
        "!":     return KBangEq;
        "=":     return KEqEq;
        "<":     return KLessEq;
        default: return KGreaterEq;
      endcase
    endfunction

    function void scan_fresh(logic [7:0] c, logic [23:0] p);
      logic [5:0] k;
      if (c == " " || c == 8'h0d || c == 8'h09) return;
      if (c == 8'h0a) begin line++; return; end
      if (c == "#") begin mode = MComment; return; end
      if (letter_byte(c)) begin
        mode = MIdent; lex_start = p; lex_len = 16'd1; prefix = {40'd0, c};
        return;
      end
      if (numeral_byte(c)) begin
        mode = MNumber; lex_start = p; lex_len = 16'd1; return;
      end
      if (c == 8'h22) begin mode = MString; lex_start = p; lex_len = 16'd1; return; end
      if (c == "*" || c == "!" || c == "=" || c == "<" || c == ">") begin
        mode = MOperator; held_op = c; lex_start = p; lex_len = 16'd1;
        return;
      end
      case (c)
        "(":     k = KLparen;
        ")":     k = KRparen;
        "{":     k = KLbrace;
        "}":     k = KRbrace;
        ";":     k = KSemi;
        ",":     k = KComma;
        ".":     k = KDot;
        "-":     k = KMinus;
        "+":     k = KPlus;
        "/":     k = KSlash;
        default: k = KUnexpected;
      endcase
      push(k, p, 16'd1);
    endfunction

    // Note an accepted input transfer and queue the tokens it produces.
    function void note_byte(logic [7:0] c, logic eos);
      logic [23:0] p;
      logic [23:0] prev;
      bit          rescan;
      p = pos; prev = pos - 1'b1; rescan = 0;
      step_tokens.delete();
      if (eos || c == 8'd0) begin
        case (mode)
          MIdent:    push(word_kind(), lex_start, lex_len);
          MNumber, MFraction: push(KNumber, lex_start, lex_len);
          MNumDot: begin push(KNumber, lex_start, lex_len); push(KDot, prev, 16'd1); end
          MString:   push(KUnterm, lex_start, lex_len);
          MOperator: push(one_char_op(held_op), lex_start, 16'd1);
          default: ;
        endcase
        push(KEof, p, 16'd0);
        clear();
      end else begin
        case (mode)
          MIdent:
            if (letter_byte(c) || numeral_byte(c)) begin
              if (lex_len < 6) prefix[8*lex_len +: 8] = c;
              lex_len = grow(lex_len, 1);
            end else begin
              push(word_kind(), lex_start, lex_len); rescan = 1;
            end
          MNumber:
            if (numeral_byte(c)) lex_len = grow(lex_len, 1);
            else if (c == ".") mode = MNumDot;
            else begin push(KNumber, lex_start, lex_len); rescan = 1; end
          MNumDot:
            if (numeral_byte(c)) begin
              lex_len = grow(lex_len, 2); mode = MFraction;
            end else begin
              push(KNumber, lex_start, lex_len); push(KDot, prev, 16'd1); rescan = 1;
            end
          MFraction:
            if (numeral_byte(c)) lex_len = grow(lex_len, 1);
            else begin push(KNumber, lex_start, lex_len); rescan = 1; end
          MString: begin
            lex_len = grow(lex_len, 1);
            if (c == 8'h22) begin
              push(KString, lex_start, lex_len); mode = MIdle;
            end else if (c == 8'h0a) begin
              line++;
            end
          end
          MComment:
            if (c == 8'h0a) rescan = 1;
          MOperator:
            if ((held_op == "*" && c == "*") || (held_op != "*" && c == "=")) begin
              push(two_char_op(held_op), lex_start, 16'd2); mode = MIdle;
            end else begin
              push(one_char_op(held_op), lex_start, 16'd1); rescan = 1;
            end
          default: rescan = 1;
        endcase
        if (rescan) begin
          mode = MIdle; held_op = 8'd0;
          scan_fresh(c, p);
        end
        pos = p + 1'b1;
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH token %0d: %s", $realtime, tokens_seen, what);
    endtask

    // Check one output transfer against the oldest queued token.
    task check_token(token_t got);
      token_t want;
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d", got.kind));
      end else begin
        want = tokens_due.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.start !== want.start)
          report_mismatch($sformatf("start %0d, want %0d", got.start, want.start));
        if (got.len !== want.len)
          report_mismatch($sformatf("length %0d, want %0d", got.len, want.len));
        if (got.line !== want.line)
          report_mismatch($sformatf("line %0d, want %0d", got.line, want.line));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
      end
      tokens_seen++;
    endtask
  endclass

  localparam int CycleLimit = 200000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [7:0]                source_byte_i = 8'd0;
  logic                      end_of_source_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [KindWidth-1:0]      token_kind_o;
  logic [OffsetWidthDef-1:0] token_start_o;
  logic [LengthWidthDef-1:0] token_length_o;
  logic [LineWidthDef-1:0]   token_line_o;
  logic                      last_of_run_o;

  token_scoreboard sb = new();
  int src_idle_pct = 0;
  int rcv_idle_pct = 0;
  int bytes_sent   = 0;
  int cycles       = 0;

  source_byte_tokenizer_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .source_byte_i, .end_of_source_i,
    .out_valid_o, .out_ready_i, .token_kind_o, .token_start_o, .token_length_o,
    .token_line_o, .last_of_run_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: end the run once the cycle count passes the limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycles,
               sb.tokens_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sample both channels at the rising edge; inputs only move on the falling edge.
  always @(posedge clk_i) begin
    token_t got;
    if (rst_ni && in_valid_i && in_ready_o) sb.note_byte(source_byte_i, end_of_source_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = token_kind_o; got.start = token_start_o; got.len = token_length_o;
      got.line = token_line_o; got.last = last_of_run_o;
      sb.check_token(got);
    end
  end

  // Receiver: stall at the current rate, decided afresh each cycle.
  always @(negedge clk_i)
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= rcv_idle_pct);

  // Offer one byte; hold it until the transfer happens.
  task send_byte(input logic [7:0] b, input logic eos);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    source_byte_i   <= b;
    end_of_source_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Close the source with either form of end marker, random payload on the flag form.
  task end_source();
    if ($urandom_range(0, 1)) send_byte(8'd0, 1'b0);
    else send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Append one random lexeme, mostly well formed, sometimes noise.
  task send_lexeme();
    string words[6];
    string s;
    string ops;
    string puncts;
    int    n;
    words = '{"and", "class", "const", "return", "while", "nil"};
    ops = "*!=<>";
    puncts = "(){};,.-+/:";
    s = "";
    case ($urandom_range(0, 11))
      0, 1: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          s = {s, string'(i == 0 ? 8'($urandom_range("a", "z"))
                         : ($urandom_range(0, 3) == 0 ? 8'($urandom_range("0", "9"))
                                                      : 8'($urandom_range("a", "z"))))};
      end
      2: s = words[$urandom_range(0, 5)];
      3: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("0", "9")))};
        case ($urandom_range(0, 2))
          0: s = {s, ".", string'(8'($urandom_range("0", "9")))};
          1: s = {s, "."};
          default: ;
        endcase
      end
      4: begin
        s = "\"";
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
          s = {s, string'($urandom_range(0, 4) == 0 ? 8'h0a : 8'($urandom_range("a", "z")))};
        if ($urandom_range(0, 5) != 0) s = {s, "\""};
      end
      5: begin
        s = string'(ops[$urandom_range(0, 4)]);
        if ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 1)) s = {s, "="};
          else s = {s, "*"};
        end
      end
      6: s = string'(puncts[$urandom_range(0, 10)]);
      7: s = "\n";
      8: s = "# note\n";
      9: s = string'(8'($urandom_range(1, 255)));
      default: s = " ";
    endcase
    send_text(s);
    if ($urandom_range(0, 2) == 0) send_byte(8'h20, 1'b0);
    if ($urandom_range(0, 40) == 0) end_source();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: every keyword, numbers, strings, operators and the end cases.
    src_idle_pct = 29; rcv_idle_pct = 54;
    send_text("and class const else false for func if nil or return true while x_1 returns");
    end_source();
    send_text("7 3.25 9.x 4. ** * != ! == = <= < >= > , ; ( ) { } + - / . :");
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text(" # tail\n\"a\nb\" \"open\n");
    end_source();
    send_text("12.");
    end_source();
    send_text("<");
    send_byte(8'h7f, 1'b1);

    // Random part over three pacing regimes; flush the source at the end of each.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 54 : 0;
      rcv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 29 : 0;
      while (bytes_sent < 60 + 120 * (ph + 1)) send_lexeme();
      end_source();
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.tokens_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("covered %0d source bytes and %0d tokens across three pacing regimes",
             bytes_sent, sb.tokens_seen);
    if (sb.mismatches == 0 && sb.tokens_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
